@@ rtl/hlf_pkg.sv @@
package hlf_pkg;

	localparam int BLOCK_COUNT = 65536;
	localparam int ADDR_W      = $clog2(BLOCK_COUNT);
	localparam int LBA_W       = 16;
	localparam int CNT_W       = 2;
	localparam int WORD_W      = 32;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CNT_W-1:0]  MAX_COUNT_RST  = CNT_W'(3);
	localparam logic [CNT_W-1:0]  HOT_THR_RST    = CNT_W'(3);
	localparam logic [WORD_W-1:0] AGE_LIMIT_RST  = WORD_W'(65536);
	localparam logic [WORD_W-1:0] COLD_START_RST = WORD_W'(65536);

	typedef enum logic [1:0] {
		ACT_UPDATE = 2'd0,
		ACT_CHECK  = 2'd1,
		ACT_REDUCE = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_COUNT  = 2'd0,
		REG_HOT_THR    = 2'd1,
		REG_AGE_LIMIT  = 2'd2,
		REG_COLD_START = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW
	} state_t;

	typedef struct packed {
		logic ready;
		logic accept;
		logic commit;
		logic sweep_step;
	} hlf_cmd_t;

	typedef struct packed {
		logic req_valid;
		logic out_busy;
		logic is_clear;
		logic sweep_last;
	} hlf_sts_t;

endpackage

@@ rtl/hlf_if.sv @@
interface hlf_req_if;
	import hlf_pkg::*;
	logic               valid;
	logic               ready;
	action_t            action;
	logic [LBA_W-1:0]   lba;
	logic               is_hot_update;
	logic               in_group_one;
	logic [WORD_W-1:0]  segment_age;
	logic               segment_in_group_zero;

	modport source (output valid, action, lba, is_hot_update, in_group_one, segment_age,
		segment_in_group_zero, input ready);
	modport sink (input valid, action, lba, is_hot_update, in_group_one, segment_age,
		segment_in_group_zero, output ready);
endinterface

interface hlf_rsp_if;
	import hlf_pkg::*;
	logic              valid;
	logic              ready;
	logic              is_hot;
	logic [CNT_W-1:0]  counter_value;
	logic [WORD_W-1:0] checks_total;
	logic [WORD_W-1:0] hot_checks_total;

	modport source (output valid, is_hot, counter_value, checks_total, hot_checks_total,
		input ready);
	modport sink (input valid, is_hot, counter_value, checks_total, hot_checks_total,
		output ready);
endinterface

interface hlf_cfg_if;
	import hlf_pkg::*;
	logic              valid;
	logic              ready;
	reg_idx_t          index;
	logic [WORD_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/hot_lba_filter_unit.sv @@
// A request transfers in the idle state; its result is registered in the read-modify-write
// state once the result register is free, and no new request is taken before that commit.
// A clear request is followed by a sweep that zeroes the whole counter RAM.
// Reset: arst_n asynchronous active low; afterwards a sweep zeroes the counter RAM,
// requests are held off during it, configuration writes are taken at all times.
module hot_lba_filter_unit
	import hlf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hlf_req_if.sink   req,
	hlf_rsp_if.source rsp,
	hlf_cfg_if.sink   cfg
);

	hlf_cmd_t cmd;
	hlf_sts_t sts;

	hlf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	hlf_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule

@@ rtl/hlf_ctrl.sv @@
module hlf_ctrl
	import hlf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  hlf_sts_t sts,
	output hlf_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (sts.req_valid) state_d = ST_RMW;
			end
			ST_RMW: begin
				if (!sts.out_busy) state_d = sts.is_clear ? ST_CLEAR : ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.sweep_step = 1'b1;
			ST_IDLE: begin
				cmd.ready  = 1'b1;
				cmd.accept = sts.req_valid;
			end
			ST_RMW: cmd.commit = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.out_busy)
		else $error("commit while result register busy");
	a_accept_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_RMW)
		else $error("accepted item not processed");
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && sts.is_clear) |=> state_q == ST_CLEAR)
		else $error("clear did not start sweep");
	a_sweep_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && !sts.sweep_last) |=> state_q == ST_CLEAR)
		else $error("sweep left early");
`endif

endmodule

@@ rtl/hlf_datapath.sv @@
module hlf_datapath
	import hlf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  hlf_cmd_t cmd,
	output hlf_sts_t sts,
	hlf_req_if.sink   req,
	hlf_rsp_if.source rsp,
	hlf_cfg_if.sink   cfg
);

	logic [CNT_W-1:0]  mem [BLOCK_COUNT];
	logic [CNT_W-1:0]  rd_q;

	logic [CNT_W-1:0]  max_count_q;
	logic [CNT_W-1:0]  hot_thr_q;
	logic [WORD_W-1:0] age_limit_q;
	logic [WORD_W-1:0] cold_left_q;
	logic [WORD_W-1:0] checks_q;
	logic [WORD_W-1:0] hot_checks_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	logic              out_valid_q;
	logic              out_hot_q;
	logic [CNT_W-1:0]  out_cnt_q;

	action_t           act_q;
	logic [ADDR_W-1:0] addr_q;
	logic              hot_upd_q;
	logic              g1_q;
	logic [WORD_W-1:0] age_q;
	logic              seg_g0_q;

	logic [CNT_W-1:0]  cnt_new;
	logic              hot_new;
	logic              cold_busy;
	logic              cfg_wr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CNT_W-1:0]  mem_wdata;

	function automatic logic [CNT_W-1:0] lower(input logic [CNT_W-1:0] v, input logic twice);
		logic [CNT_W-1:0] step;
		step = twice ? CNT_W'(2) : CNT_W'(1);
		return (v > step) ? CNT_W'(v - step) : '0;
	endfunction

	assign cfg_wr    = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;
	assign req.ready = cmd.ready;
	assign cold_busy = (cold_left_q != '0);

	assign sts.req_valid  = req.valid;
	assign sts.out_busy   = out_valid_q && !rsp.ready;
	assign sts.is_clear   = (act_q == ACT_CLEAR);
	assign sts.sweep_last = &sweep_addr_q;

	always_comb begin
		cnt_new = rd_q;
		hot_new = 1'b0;
		unique case (act_q)
			ACT_UPDATE: begin
				if (cold_busy) begin
					cnt_new = rd_q;
				end else if (hot_upd_q) begin
					if (g1_q) begin
						if (age_q <= age_limit_q) begin
							if (rd_q < max_count_q) cnt_new = CNT_W'(rd_q + 1'b1);
						end else if (rd_q != '0) begin
							cnt_new = CNT_W'(rd_q - 1'b1);
						end
					end
				end else begin
					cnt_new = lower(rd_q, seg_g0_q);
				end
			end
			ACT_CHECK:  hot_new = (rd_q >= hot_thr_q);
			ACT_REDUCE: cnt_new = lower(rd_q, !seg_g0_q);
			ACT_CLEAR:  cnt_new = '0;
			default:    cnt_new = rd_q;
		endcase
	end

	assign mem_we    = cmd.commit || cmd.sweep_step;
	assign mem_waddr = cmd.sweep_step ? sweep_addr_q : addr_q;
	assign mem_wdata = cmd.sweep_step ? '0 : cnt_new;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.accept) rd_q <= mem[req.lba[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q     <= req.action;
			addr_q    <= req.lba[ADDR_W-1:0];
			hot_upd_q <= req.is_hot_update;
			g1_q      <= req.in_group_one;
			age_q     <= req.segment_age;
			seg_g0_q  <= req.segment_in_group_zero;
		end
		if (cmd.commit) begin
			out_hot_q <= hot_new;
			out_cnt_q <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q  <= MAX_COUNT_RST;
			hot_thr_q    <= HOT_THR_RST;
			age_limit_q  <= AGE_LIMIT_RST;
			cold_left_q  <= COLD_START_RST;
			checks_q     <= '0;
			hot_checks_q <= '0;
			sweep_addr_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg.index)
					REG_MAX_COUNT:  max_count_q <= cfg.data[CNT_W-1:0];
					REG_HOT_THR:    hot_thr_q   <= cfg.data[CNT_W-1:0];
					REG_AGE_LIMIT:  age_limit_q <= cfg.data;
					REG_COLD_START: cold_left_q <= cfg.data;
					default:        max_count_q <= max_count_q;
				endcase
			end else if (cmd.commit && act_q == ACT_UPDATE && cold_busy) begin
				cold_left_q <= cold_left_q - 1'b1;
			end
			if (cmd.commit && act_q == ACT_CHECK) begin
				if (!(&checks_q)) checks_q <= checks_q + 1'b1;
				if (hot_new && !(&hot_checks_q)) hot_checks_q <= hot_checks_q + 1'b1;
			end
			if (cmd.sweep_step) sweep_addr_q <= ADDR_W'(sweep_addr_q + 1'b1);
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.is_hot           = out_hot_q;
	assign rsp.counter_value    = out_cnt_q;
	assign rsp.checks_total     = checks_q;
	assign rsp.hot_checks_total = hot_checks_q;

`ifndef SYNTHESIS
	a_stats_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(checks_q) && $stable(hot_checks_q))
		else $error("totals changed under a pending result");
	a_hot_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && act_q != ACT_CHECK) |=> $stable(checks_q) && $stable(hot_checks_q))
		else $error("totals moved on a non-check item");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.counter_value) &&
		$stable(rsp.is_hot))
		else $error("pending result dropped or changed");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import hlf_pkg::*;

	localparam int CYCLE_LIMIT    = 2_500_000;
	localparam int DRAIN_TAIL     = 16;
	localparam int RAND_SUBPHASES = 12;
	localparam int SUBPHASE_ITEMS = 96;
	localparam int CLEAR_SLOT     = 48;

	typedef struct packed {
		action_t           act;
		logic [LBA_W-1:0]  lba;
		logic              hot_upd;
		logic              grp_one;
		logic [WORD_W-1:0] age;
		logic              seg_g0;
	} lba_req_t;

	typedef struct packed {
		logic              is_hot;
		logic [CNT_W-1:0]  cnt;
		logic [WORD_W-1:0] checks;
		logic [WORD_W-1:0] hot_checks;
	} hot_result_t;

	typedef struct packed {
		logic              is_cfg;
		reg_idx_t          reg_sel;
		logic [WORD_W-1:0] wdata;
		lba_req_t          item;
		logic              known;
		hot_result_t       res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	hlf_req_if req_bus();
	hlf_rsp_if rsp_bus();
	hlf_cfg_if cfg_bus();

	hot_lba_filter_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	logic [CNT_W-1:0]  hot_counters [BLOCK_COUNT];
	logic [WORD_W-1:0] cold_left;
	logic [WORD_W-1:0] chk_cnt;
	logic [WORD_W-1:0] hot_chk_cnt;
	logic [CNT_W-1:0]  cfg_max;
	logic [CNT_W-1:0]  cfg_thr;
	logic [WORD_W-1:0] cfg_age;
	logic [WORD_W-1:0] cfg_cold_len;

	hot_result_t       pending_results [$];
	stim_row_t         dir_rows [$];
	logic [LBA_W-1:0]  lba_pool [8];
	hot_result_t       seen_exp;
	int unsigned       mismatch_count;
	int unsigned       cycle_count;
	int                src_idle_pct;
	int                snk_idle_pct;

	logic [CNT_W-1:0] max_plan [RAND_SUBPHASES] =
		'{2'd3, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd1};
	logic [CNT_W-1:0] thr_plan [RAND_SUBPHASES] =
		'{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0};

	function automatic logic [CNT_W-1:0] drop_count(logic [CNT_W-1:0] c, logic twice);
		int unsigned step;
		step = twice ? 2 : 1;
		if (c == 0)
			return '0;
		return (c > step) ? CNT_W'(c - step) : '0;
	endfunction

	function automatic hot_result_t apply_lba_action(lba_req_t r);
		hot_result_t      o;
		logic [CNT_W-1:0] c;
		o = '0;
		c = hot_counters[r.lba];
		case (r.act)
			ACT_UPDATE: begin
				if (cold_left != 0) begin
					cold_left--;
				end else if (r.hot_upd) begin
					if (r.grp_one) begin
						if (r.age <= cfg_age) begin
							if (c < cfg_max)
								c++;
						end else if (c != 0) begin
							c--;
						end
					end
				end else begin
					c = drop_count(c, r.seg_g0);
				end
				hot_counters[r.lba] = c;
			end
			ACT_CHECK: begin
				if (chk_cnt != '1)
					chk_cnt++;
				if (c >= cfg_thr) begin
					o.is_hot = 1'b1;
					if (hot_chk_cnt != '1)
						hot_chk_cnt++;
				end
			end
			ACT_REDUCE: begin
				c = drop_count(c, !r.seg_g0);
				hot_counters[r.lba] = c;
			end
			default: begin
				foreach (hot_counters[i])
					hot_counters[i] = '0;
				c = '0;
			end
		endcase
		o.cnt        = c;
		o.checks     = chk_cnt;
		o.hot_checks = hot_chk_cnt;
		return o;
	endfunction

	function automatic void add_row(action_t a, logic [LBA_W-1:0] lba, logic hu, logic g1,
		logic [WORD_W-1:0] age, logic g0);
		stim_row_t row;
		row = '0;
		row.item = '{act: a, lba: lba, hot_upd: hu, grp_one: g1, age: age, seg_g0: g0};
		dir_rows.push_back(row);
	endfunction

	function automatic void mark_known(logic h, logic [CNT_W-1:0] c, logic [WORD_W-1:0] ck,
		logic [WORD_W-1:0] hk);
		dir_rows[dir_rows.size()-1].known = 1'b1;
		dir_rows[dir_rows.size()-1].res   = '{is_hot: h, cnt: c, checks: ck, hot_checks: hk};
	endfunction

	function automatic void add_cfg(reg_idx_t idx, logic [WORD_W-1:0] val);
		stim_row_t row;
		row         = '0;
		row.is_cfg  = 1'b1;
		row.reg_sel = idx;
		row.wdata   = val;
		row.item.act = ACT_CHECK;
		dir_rows.push_back(row);
	endfunction

	function automatic lba_req_t random_item();
		lba_req_t r;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 50)
			r.act = ACT_UPDATE;
		else if (pick < 75)
			r.act = ACT_CHECK;
		else
			r.act = ACT_REDUCE;
		r.lba     = ($urandom_range(99) < 85) ? lba_pool[$urandom_range(7)] : LBA_W'($urandom);
		r.hot_upd = ($urandom_range(99) < 70);
		r.grp_one = ($urandom_range(99) < 75);
		r.seg_g0  = 1'($urandom_range(1));
		case ($urandom_range(4))
			0: r.age = $urandom;
			1: r.age = cfg_age;
			2: r.age = cfg_age + 1;
			3: r.age = cfg_age - 1;
			default: r.age = $urandom_range(16);
		endcase
		return r;
	endfunction

	task automatic flag_field(string fld, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
			mismatch_count++;
		end
	endtask

	task automatic send_item(lba_req_t r, logic known, hot_result_t typed_res);
		hot_result_t pred;
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			req_bus.valid = 1'b0;
			@(negedge clk);
		end
		req_bus.valid                 = 1'b1;
		req_bus.action                = r.act;
		req_bus.lba                   = r.lba;
		req_bus.is_hot_update         = r.hot_upd;
		req_bus.in_group_one          = r.grp_one;
		req_bus.segment_age           = r.age;
		req_bus.segment_in_group_zero = r.seg_g0;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		pred = apply_lba_action(r);
		pending_results.push_back(known ? typed_res : pred);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [WORD_W-1:0] val);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data  = val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			REG_MAX_COUNT: cfg_max = val[CNT_W-1:0];
			REG_HOT_THR:   cfg_thr = val[CNT_W-1:0];
			REG_AGE_LIMIT: cfg_age = val;
			default: begin
				cfg_cold_len = val;
				cold_left    = val;
			end
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_bus.ready = (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transfer, actual %0h %0h %0h %0h", $time,
					rsp_bus.is_hot, rsp_bus.counter_value, rsp_bus.checks_total,
					rsp_bus.hot_checks_total);
				mismatch_count++;
			end else begin
				seen_exp = pending_results.pop_front();
				flag_field("is_hot", WORD_W'(seen_exp.is_hot), WORD_W'(rsp_bus.is_hot));
				flag_field("counter_value", WORD_W'(seen_exp.cnt),
					WORD_W'(rsp_bus.counter_value));
				flag_field("checks_total", seen_exp.checks, rsp_bus.checks_total);
				flag_field("hot_checks_total", seen_exp.hot_checks, rsp_bus.hot_checks_total);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		lba_req_t item;
		stim_row_t row;

		mismatch_count = 0;
		cycle_count    = 0;
		src_idle_pct   = 30;
		snk_idle_pct   = 74;

		req_bus.valid                 = 1'b0;
		req_bus.action                = ACT_UPDATE;
		req_bus.lba                   = '0;
		req_bus.is_hot_update         = 1'b0;
		req_bus.in_group_one          = 1'b0;
		req_bus.segment_age           = '0;
		req_bus.segment_in_group_zero = 1'b0;
		cfg_bus.valid                 = 1'b0;
		cfg_bus.index                 = REG_MAX_COUNT;
		cfg_bus.data                  = '0;

		foreach (hot_counters[i])
			hot_counters[i] = '0;
		cfg_max      = MAX_COUNT_RST;
		cfg_thr      = HOT_THR_RST;
		cfg_age      = AGE_LIMIT_RST;
		cfg_cold_len = COLD_START_RST;
		cold_left    = COLD_START_RST;
		chk_cnt      = '0;
		hot_chk_cnt  = '0;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(ACT_CHECK, 16'h0000, 0, 0, 0, 0);              mark_known(0, 0, 1, 0);
		add_row(ACT_UPDATE, 16'hFFFF, 1, 1, 0, 1);             mark_known(0, 0, 1, 0);
		add_cfg(REG_COLD_START, 32'hFFFF_FFFF);
		add_row(ACT_UPDATE, 16'hFFFF, 0, 1, 0, 1);             mark_known(0, 0, 1, 0);
		add_cfg(REG_COLD_START, 32'd1);
		add_row(ACT_UPDATE, 16'h0005, 1, 1, 0, 0);             mark_known(0, 0, 1, 0);
		add_row(ACT_UPDATE, 16'h0005, 1, 1, 32'd65536, 0);     mark_known(0, 1, 1, 0);
		add_row(ACT_UPDATE, 16'h0005, 1, 1, 32'd65536, 0);     mark_known(0, 2, 1, 0);
		add_row(ACT_UPDATE, 16'h0005, 1, 1, 32'd65536, 0);     mark_known(0, 3, 1, 0);
		add_row(ACT_UPDATE, 16'h0005, 1, 1, 32'd65536, 0);     mark_known(0, 3, 1, 0);
		add_row(ACT_CHECK, 16'h0005, 0, 0, 0, 0);              mark_known(1, 3, 2, 1);
		add_row(ACT_UPDATE, 16'h0005, 1, 1, 32'd65537, 0);
		add_row(ACT_UPDATE, 16'h0005, 1, 0, 0, 0);
		add_row(ACT_UPDATE, 16'h0005, 0, 0, 0, 1);
		add_row(ACT_REDUCE, 16'h0005, 0, 0, 0, 0);
		add_row(ACT_UPDATE, 16'h0006, 0, 1, 0, 0);
		add_cfg(REG_MAX_COUNT, 32'd1);
		add_cfg(REG_HOT_THR, 32'd0);
		add_cfg(REG_AGE_LIMIT, 32'hFFFF_FFFF);
		add_row(ACT_UPDATE, 16'h0007, 1, 1, 32'hFFFF_FFFF, 0);
		add_row(ACT_UPDATE, 16'h0007, 1, 1, 32'hFFFF_FFFF, 0);
		add_row(ACT_CHECK, 16'h8000, 0, 0, 0, 0);              mark_known(1, 0, 3, 2);
		add_cfg(REG_MAX_COUNT, 32'd3);
		add_row(ACT_UPDATE, 16'h0007, 1, 1, 0, 0);
		add_row(ACT_UPDATE, 16'h0007, 1, 1, 0, 0);
		add_cfg(REG_MAX_COUNT, 32'd0);
		add_cfg(REG_HOT_THR, 32'd2);
		add_cfg(REG_AGE_LIMIT, 32'd0);
		add_row(ACT_UPDATE, 16'h0007, 1, 1, 0, 0);
		add_row(ACT_UPDATE, 16'h0009, 1, 1, 0, 0);
		add_row(ACT_REDUCE, 16'h0007, 0, 0, 0, 1);
		add_row(ACT_CHECK, 16'h0007, 0, 0, 0, 0);
		add_row(ACT_UPDATE, 16'h0007, 0, 0, 0, 0);
		add_row(ACT_UPDATE, 16'h0007, 1, 1, 32'd1, 1);
		add_row(ACT_CLEAR, 16'hAAAA, 1, 1, 32'h5555_5555, 1);
		add_row(ACT_CHECK, 16'h0007, 0, 0, 0, 0);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_cfg) begin
				drain_results();
				write_reg(row.reg_sel, row.wdata);
			end else begin
				send_item(row.item, row.known, row.res);
			end
		end

		for (int sub = 0; sub < RAND_SUBPHASES; sub++) begin
			drain_results();
			case (sub / 4)
				0: begin
					src_idle_pct = 30;
					snk_idle_pct = 74;
				end
				1: begin
					src_idle_pct = 74;
					snk_idle_pct = 30;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			write_reg(REG_MAX_COUNT, WORD_W'(max_plan[sub]));
			write_reg(REG_HOT_THR, WORD_W'(thr_plan[sub]));
			case (sub % 4)
				0: write_reg(REG_AGE_LIMIT, $urandom);
				1: write_reg(REG_AGE_LIMIT, '0);
				2: write_reg(REG_AGE_LIMIT, '1);
				default: write_reg(REG_AGE_LIMIT, $urandom_range(64));
			endcase
			write_reg(REG_COLD_START, (sub % 3 == 0) ? '0 : WORD_W'($urandom_range(1, 6)));
			foreach (lba_pool[k])
				lba_pool[k] = LBA_W'($urandom);
			for (int n = 0; n < SUBPHASE_ITEMS; n++) begin
				item = random_item();
				if (sub % 3 == 1 && n == CLEAR_SLOT)
					item.act = ACT_CLEAR;
				send_item(item, 1'b0, '0);
			end
		end

		drain_results();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
